>>> hw/rtl/segment_rect_intersect_test_assert.svh
// Assertion helpers used by the checker file.
`ifndef SEGMENT_RECT_INTERSECT_TEST_ASSERT_SVH
`define SEGMENT_RECT_INTERSECT_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SRI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SRI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sri_pkg.sv
package sri_pkg;

  // Rectangle corner order used for the orientation signs
  localparam int NUM_CORNERS = 4;
  localparam int CORNER_LT   = 0;
  localparam int CORNER_LB   = 1;
  localparam int CORNER_RB   = 2;
  localparam int CORNER_RT   = 3;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_RECT_LEFT   = 2'd0;
  localparam cfg_idx_t REG_RECT_TOP    = 2'd1;
  localparam cfg_idx_t REG_RECT_RIGHT  = 2'd2;
  localparam cfg_idx_t REG_RECT_BOTTOM = 2'd3;

  // Result bus: one flag padded to a byte
  localparam int OUT_TDATA_W = 8;

  // Early decisions made from plain compares in the first stage.
  // sep_* is set when both segment endpoints lie strictly on one side
  // of that (non-degenerate) rectangle edge line.
  typedef struct packed {
    logic pt_inside;
    logic sep_left;
    logic sep_bottom;
    logic sep_right;
    logic sep_top;
  } edge_flags_t;

  // Strict sign of each corner's cross product against the segment
  typedef struct packed {
    logic [NUM_CORNERS-1:0] pos;
    logic [NUM_CORNERS-1:0] neg;
  } corner_sign_t;

endpackage

>>> hw/rtl/sri_prep.sv
module sri_prep #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] rect_left,
  input  logic signed [COORD_BITS-1:0] rect_top,
  input  logic signed [COORD_BITS-1:0] rect_right,
  input  logic signed [COORD_BITS-1:0] rect_bottom,
  output logic signed [COORD_BITS:0]   dx_r,
  output logic signed [COORD_BITS:0]   dy_r,
  output logic signed [COORD_BITS:0]   dyt_r,
  output logic signed [COORD_BITS:0]   dyb_r,
  output logic signed [COORD_BITS:0]   dxl_r,
  output logic signed [COORD_BITS:0]   dxr_r,
  output sri_pkg::edge_flags_t         flags_r
);
  import sri_pkg::*;

  localparam int D = COORD_BITS + 1;

  logic [D-1:0] sx_e, sy_e, ex_e, ey_e, l_e, t_e, r_e, b_e;
  logic         in_s, in_e;
  edge_flags_t  flags_nxt;

  // Sign-extend one bit so every difference is exact
  assign sx_e = {start_x[COORD_BITS-1], start_x};
  assign sy_e = {start_y[COORD_BITS-1], start_y};
  assign ex_e = {end_x[COORD_BITS-1], end_x};
  assign ey_e = {end_y[COORD_BITS-1], end_y};
  assign l_e  = {rect_left[COORD_BITS-1], rect_left};
  assign t_e  = {rect_top[COORD_BITS-1], rect_top};
  assign r_e  = {rect_right[COORD_BITS-1], rect_right};
  assign b_e  = {rect_bottom[COORD_BITS-1], rect_bottom};

  // Inclusive point-in-rectangle for both endpoints
  assign in_s = (start_x >= rect_left) && (start_x <= rect_right) &&
                (start_y >= rect_top)  && (start_y <= rect_bottom);
  assign in_e = (end_x >= rect_left) && (end_x <= rect_right) &&
                (end_y >= rect_top)  && (end_y <= rect_bottom);

  // Axis-aligned edges: endpoint orientation reduces to a compare
  always_comb begin
    flags_nxt.pt_inside  = in_s || in_e;
    flags_nxt.sep_left   = (rect_bottom != rect_top) &&
                           (((start_x < rect_left) && (end_x < rect_left)) ||
                            ((start_x > rect_left) && (end_x > rect_left)));
    flags_nxt.sep_right  = (rect_bottom != rect_top) &&
                           (((start_x < rect_right) && (end_x < rect_right)) ||
                            ((start_x > rect_right) && (end_x > rect_right)));
    flags_nxt.sep_bottom = (rect_right != rect_left) &&
                           (((start_y < rect_bottom) && (end_y < rect_bottom)) ||
                            ((start_y > rect_bottom) && (end_y > rect_bottom)));
    flags_nxt.sep_top    = (rect_right != rect_left) &&
                           (((start_y < rect_top) && (end_y < rect_top)) ||
                            ((start_y > rect_top) && (end_y > rect_top)));
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r    <= ex_e - sx_e;
      dy_r    <= ey_e - sy_e;
      dyt_r   <= t_e - sy_e;
      dyb_r   <= b_e - sy_e;
      dxl_r   <= l_e - sx_e;
      dxr_r   <= r_e - sx_e;
      flags_r <= flags_nxt;
    end
  end

endmodule

>>> hw/rtl/sri_cross.sv
module sri_cross #(
  parameter int COORD_BITS = 16
) (
  input  logic                       clk,
  input  logic                       en_mul,
  input  logic                       en_cmp,
  input  logic signed [COORD_BITS:0] dx,
  input  logic signed [COORD_BITS:0] dy,
  input  logic signed [COORD_BITS:0] dyt,
  input  logic signed [COORD_BITS:0] dyb,
  input  logic signed [COORD_BITS:0] dxl,
  input  logic signed [COORD_BITS:0] dxr,
  input  sri_pkg::edge_flags_t       flags_i,
  output sri_pkg::edge_flags_t       flags_r,
  output sri_pkg::corner_sign_t      signs_r
);
  import sri_pkg::*;

  localparam int P = 2 * (COORD_BITS + 1);

  logic signed [P-1:0] m_xt_r, m_xb_r, m_yl_r, m_yr_r;
  edge_flags_t         flags_m_r;
  corner_sign_t        signs_nxt;

  // Stage 2: the four distinct products of corner = dx*(qy-sy) - dy*(qx-sx)
  always_ff @(posedge clk) begin
    if (en_mul) begin
      m_xt_r    <= dx * dyt;
      m_xb_r    <= dx * dyb;
      m_yl_r    <= dy * dxl;
      m_yr_r    <= dy * dxr;
      flags_m_r <= flags_i;
    end
  end

  // Stage 3: strict sign of each corner's cross product
  always_comb begin
    signs_nxt.pos[CORNER_LT] = m_xt_r > m_yl_r;
    signs_nxt.neg[CORNER_LT] = m_xt_r < m_yl_r;
    signs_nxt.pos[CORNER_LB] = m_xb_r > m_yl_r;
    signs_nxt.neg[CORNER_LB] = m_xb_r < m_yl_r;
    signs_nxt.pos[CORNER_RB] = m_xb_r > m_yr_r;
    signs_nxt.neg[CORNER_RB] = m_xb_r < m_yr_r;
    signs_nxt.pos[CORNER_RT] = m_xt_r > m_yr_r;
    signs_nxt.neg[CORNER_RT] = m_xt_r < m_yr_r;
  end

  always_ff @(posedge clk) begin
    if (en_cmp) begin
      signs_r <= signs_nxt;
      flags_r <= flags_m_r;
    end
  end

endmodule

>>> hw/rtl/segment_rect_intersect_test.sv
// Segment versus rectangle hit test, four register stages deep.
// The request is captured by prep at the accepting edge, then moves through
// the multiply, compare and result registers; the last one drives out_tvalid.
// One request per cycle sustained while out_tready stays high.
// A stalled result holds in the output register while bubbles still fill.
// Synchronous active-low reset clears all valid bits and the rectangle to 0.
module segment_rect_intersect_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_x, start_y, end_x, end_y, zero pad to whole bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // hits, zero pad
  output logic [sri_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                 cfg_wr_en,
  input  sri_pkg::cfg_idx_t                    cfg_addr,
  input  logic [COORD_BITS-1:0]                cfg_wdata
);
  import sri_pkg::*;

  logic signed [COORD_BITS-1:0] rect_left_r, rect_top_r, rect_right_r, rect_bottom_r;
  logic                         v1_r, v2_r, v3_r, out_vld_r;
  logic                         en1, en2, en3, en_out;
  logic signed [COORD_BITS:0]   dx, dy, dyt, dyb, dxl, dxr;
  edge_flags_t                  flags1, flags3;
  corner_sign_t                 signs3;
  logic                         hits_nxt, hits_r;
  logic                         meet_l, meet_b, meet_r, meet_t;

  // Rectangle registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r   <= '0;
      rect_top_r    <= '0;
      rect_right_r  <= '0;
      rect_bottom_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_RECT_LEFT:   rect_left_r   <= cfg_wdata;
        REG_RECT_TOP:    rect_top_r    <= cfg_wdata;
        REG_RECT_RIGHT:  rect_right_r  <= cfg_wdata;
        REG_RECT_BOTTOM: rect_bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage advance: a stage moves when it is empty or its successor moves
  assign en_out    = !out_vld_r || out_tready;
  assign en3       = !v3_r || en_out;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en1)    v1_r      <= in_tvalid;
      if (en2)    v2_r      <= v1_r;
      if (en3)    v3_r      <= v2_r;
      if (en_out) out_vld_r <= v3_r;
    end
  end

  sri_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk         (clk),
    .en          (en1),
    .start_x     (in_tdata[COORD_BITS-1:0]),
    .start_y     (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x       (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y       (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .rect_left   (rect_left_r),
    .rect_top    (rect_top_r),
    .rect_right  (rect_right_r),
    .rect_bottom (rect_bottom_r),
    .dx_r        (dx),
    .dy_r        (dy),
    .dyt_r       (dyt),
    .dyb_r       (dyb),
    .dxl_r       (dxl),
    .dxr_r       (dxr),
    .flags_r     (flags1)
  );

  sri_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk     (clk),
    .en_mul  (en2),
    .en_cmp  (en3),
    .dx      (dx),
    .dy      (dy),
    .dyt     (dyt),
    .dyb     (dyb),
    .dxl     (dxl),
    .dxr     (dxr),
    .flags_i (flags1),
    .flags_r (flags3),
    .signs_r (signs3)
  );

  // An edge is missed if the segment is strictly beside its line, or both
  // corners of the edge are strictly on one side of the segment line
  assign meet_l = !flags3.sep_left &&
                  !((signs3.pos[CORNER_LT] && signs3.pos[CORNER_LB]) ||
                    (signs3.neg[CORNER_LT] && signs3.neg[CORNER_LB]));
  assign meet_b = !flags3.sep_bottom &&
                  !((signs3.pos[CORNER_LB] && signs3.pos[CORNER_RB]) ||
                    (signs3.neg[CORNER_LB] && signs3.neg[CORNER_RB]));
  assign meet_r = !flags3.sep_right &&
                  !((signs3.pos[CORNER_RB] && signs3.pos[CORNER_RT]) ||
                    (signs3.neg[CORNER_RB] && signs3.neg[CORNER_RT]));
  assign meet_t = !flags3.sep_top &&
                  !((signs3.pos[CORNER_LT] && signs3.pos[CORNER_RT]) ||
                    (signs3.neg[CORNER_LT] && signs3.neg[CORNER_RT]));

  assign hits_nxt = flags3.pt_inside || meet_l || meet_b || meet_r || meet_t;

  // Result register
  always_ff @(posedge clk) begin
    if (en_out) hits_r <= hits_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W-1)'(0), hits_r};

endmodule

>>> hw/rtl/sri_checker.sv
module sri_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sri_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sri_pkg::*;

  `include "segment_rect_intersect_test_assert.svh"

  // A free output slot means the whole pipe can move
  `SRI_ASSERT_IMP(a_ready_when_drain, (!out_tvalid || out_tready), in_tready, "input stalled")

  // Unstalled request reaches the output after four stages
  `SRI_ASSERT_NXT(a_latency, (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready, out_tvalid, "result late")

  // Held result stays put
  `SRI_ASSERT_NXT(a_out_hold, (out_tvalid && !out_tready), (out_tvalid && $stable(out_tdata)), "held result changed")

endmodule

bind segment_rect_intersect_test sri_checker u_sri_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
